>>> rtl/view_frustum_culler_top_macros.svh
// Assertion macros used by the checker file of the frustum culler.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef VIEW_FRUSTUM_CULLER_TOP_MACROS_SVH
`define VIEW_FRUSTUM_CULLER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VFC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vfc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define VFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vfc assertion failed");

`endif

>>> rtl/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and constants of the view frustum culler: item modes, the
// datapath command and status structs and the controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vfc_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int SQRT_STEPS_DEF = 32;
    localparam int PLANE_COUNT    = 6;

    typedef logic [2:0] mode_t;

    localparam mode_t MODE_LOAD_MV = 3'd0;
    localparam mode_t MODE_LOAD_PJ = 3'd1;
    localparam mode_t MODE_EXTRACT = 3'd2;
    localparam mode_t MODE_POINT   = 3'd3;
    localparam mode_t MODE_SPHERE  = 3'd4;
    localparam mode_t MODE_CUBE    = 3'd5;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_ACC_CLR,
        OP_MUL_CLIP,
        OP_MUL_TEST,
        OP_MUL_SQ,
        OP_ACC_SHIFT,
        OP_ACC_RAW,
        OP_ACC_D,
        OP_CLIP_STORE,
        OP_RAW_W,
        OP_RAW_E,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_STORE,
        OP_TEST_CMP,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] entry;    // clip entry, row in the upper bits
        logic [1:0] k;        // inner product term
        logic [2:0] plane;
        logic [1:0] comp;     // plane component a, b, c, d
        logic [4:0] bit_idx;  // square root bit under trial
    } dp_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  out_free;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_CLIP_CLR,
        S_CLIP_MUL,
        S_CLIP_ACC,
        S_CLIP_STORE,
        S_RAW_W,
        S_RAW_E,
        S_SQ_CLR,
        S_SQ_MUL,
        S_SQ_ACC,
        S_SQRT_INIT,
        S_SQRT_STEP,
        S_DIV_INIT,
        S_DIV_STEP,
        S_DIV_STORE,
        S_TEST_CLR,
        S_TEST_MUL,
        S_TEST_ACC,
        S_TEST_D,
        S_TEST_CMP,
        S_FINISH
    } ctl_state_t;

endpackage

`default_nettype wire

>>> rtl/vfc_item_if.sv
// ----------------------------------------------------------------------------
// vfc_item_if
// Input channel of the frustum culler: one item per valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vfc_item_if;
    import vfc_pkg::*;

    logic               valid;
    logic               ready;
    mode_t              mode;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    logic [30:0]        extent;

    modport source (
        output valid, mode, element_index, element_value,
        output x_coord, y_coord, z_coord, extent,
        input  ready
    );

    modport sink (
        input  valid, mode, element_index, element_value,
        input  x_coord, y_coord, z_coord, extent,
        output ready
    );

endinterface

`default_nettype wire

>>> rtl/vfc_result_if.sv
// ----------------------------------------------------------------------------
// vfc_result_if
// Output channel of the frustum culler: one result item per handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vfc_result_if;

    logic valid;
    logic ready;
    logic visible;
    logic degenerate;

    modport source (output valid, visible, degenerate, input ready);
    modport sink (input valid, visible, degenerate, output ready);

endinterface

`default_nettype wire

>>> rtl/vfc_datapath.sv
// ----------------------------------------------------------------------------
// vfc_datapath
// Matrix and plane stores, shared multiplier and accumulator, bit-serial
// square root and restoring divider, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vfc_datapath #(
    parameter int FRAC_BITS = vfc_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  vfc_pkg::dp_cmd_t   cmd,
    output vfc_pkg::dp_status_t status,
    input  vfc_pkg::mode_t     item_mode,
    input  logic [3:0]         item_element_index,
    input  logic signed [31:0] item_element_value,
    input  logic signed [31:0] item_x_coord,
    input  logic signed [31:0] item_y_coord,
    input  logic signed [31:0] item_z_coord,
    input  logic [30:0]        item_extent,
    output logic               result_valid,
    input  logic               result_ready,
    output logic               result_visible,
    output logic               result_degenerate
);
    import vfc_pkg::*;

    localparam int NW = 32 + FRAC_BITS;  // dividend width

    localparam logic signed [71:0] SAT_MAX = 72'sh7FFFFFFF;
    localparam logic signed [71:0] SAT_MIN = -SAT_MAX - 72'sd1;

    function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic signed [31:0] mv_reg    [16];
    logic signed [31:0] pj_reg    [16];
    logic signed [31:0] plane_reg [24];
    logic signed [31:0] clip_reg  [16];
    logic signed [31:0] raw_reg   [4];

    mode_t              mode_reg;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [30:0]        ext_reg;
    logic signed [64:0] prod_reg;
    logic signed [71:0] acc_reg;
    logic signed [31:0] tmp_reg;
    logic [63:0]        s_reg;
    logic [31:0]        root_reg;
    logic [63:0]        sq_reg;
    logic [NW-1:0]      dvd_reg;
    logic [31:0]        rem_reg;
    logic [NW-1:0]      quo_reg;
    logic               vis_reg;
    logic               degen_reg;
    logic               out_valid_reg;
    logic               out_vis_reg;
    logic               out_degen_reg;

    logic [4:0]         plane_addr;
    logic signed [31:0] plane_rd;
    logic [3:0]         clip_addr;
    logic signed [31:0] clip_rd;
    logic signed [31:0] raw_rd;
    logic signed [32:0] coord;
    logic signed [32:0] ext_s;
    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] mul_p;
    logic               minus;
    logic signed [71:0] raw_sum;
    logic [64:0]        trial_sq;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [31:0]        mag;
    logic signed [31:0] quo_sat;
    logic signed [71:0] limit;

    assign plane_addr = {cmd.plane, cmd.comp};
    assign plane_rd   = plane_reg[plane_addr];
    assign clip_addr  = (cmd.op == OP_RAW_W) ? {cmd.comp, 2'd3} : {cmd.comp, cmd.plane[2:1]};
    assign clip_rd    = clip_reg[clip_addr];
    assign raw_rd     = raw_reg[cmd.comp];
    assign ext_s      = $signed({2'b00, ext_reg});

    // For a cube the corner that maximises each term is taken per axis.
    always_comb
    begin
        case (cmd.comp)
            2'd0:    coord = 33'(x_reg);
            2'd1:    coord = 33'(y_reg);
            default: coord = 33'(z_reg);
        endcase
        if (mode_reg == MODE_CUBE)
        begin
            coord = plane_rd[31] ? (coord - ext_s) : (coord + ext_s);
        end
    end

    always_comb
    begin
        case (cmd.op)
            OP_MUL_CLIP:
            begin
                mul_a = mv_reg[{cmd.entry[3:2], cmd.k}];
                mul_b = 33'(pj_reg[{cmd.k, cmd.entry[1:0]}]);
            end
            OP_MUL_SQ:
            begin
                mul_a = raw_rd;
                mul_b = 33'(raw_rd);
            end
            default:
            begin
                mul_a = plane_rd;
                mul_b = coord;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign minus   = (cmd.plane == 3'd0) || (cmd.plane == 3'd3) || (cmd.plane == 3'd4);
    assign raw_sum = minus ? (72'(tmp_reg) - 72'(clip_rd)) : (72'(tmp_reg) + 72'(clip_rd));

    assign trial_sq = 65'(sq_reg) + (65'(root_reg) << (6'(cmd.bit_idx) + 6'd1))
                    + (65'd1 << {cmd.bit_idx, 1'b0});

    assign rem_sh = {rem_reg, dvd_reg[NW-1]};
    assign rem_ge = rem_sh >= {1'b0, root_reg};
    assign mag    = raw_rd[31] ? (~raw_rd + 32'd1) : raw_rd;

    always_comb
    begin
        if (raw_rd[31])
        begin
            if (quo_reg >= {{FRAC_BITS{1'b0}}, 32'h80000000})
            begin
                quo_sat = 32'sh80000000;
            end
            else
            begin
                quo_sat = -$signed(quo_reg[31:0]);
            end
        end
        else
        begin
            if (quo_reg > {{FRAC_BITS{1'b0}}, 32'h7FFFFFFF})
            begin
                quo_sat = 32'sh7FFFFFFF;
            end
            else
            begin
                quo_sat = $signed(quo_reg[31:0]);
            end
        end
    end

    assign limit = (mode_reg == MODE_SPHERE) ? -$signed({41'd0, ext_reg}) : 72'sd0;

    // Stores with a defined reset value, and control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                mv_reg[i] <= '0;
                pj_reg[i] <= '0;
            end
            for (int i = 0; i < 24; i++)
            begin
                plane_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CAPTURE && item_mode == MODE_LOAD_MV)
            begin
                mv_reg[item_element_index] <= item_element_value;
            end
            if (cmd.op == OP_CAPTURE && item_mode == MODE_LOAD_PJ)
            begin
                pj_reg[item_element_index] <= item_element_value;
            end
            if (cmd.op == OP_DIV_STORE)
            begin
                plane_reg[plane_addr] <= (root_reg == 32'd0) ? 32'sd0 : quo_sat;
            end
            if (cmd.op == OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                mode_reg  <= item_mode;
                x_reg     <= item_x_coord;
                y_reg     <= item_y_coord;
                z_reg     <= item_z_coord;
                ext_reg   <= item_extent;
                vis_reg   <= (item_mode == MODE_POINT) || (item_mode == MODE_SPHERE)
                          || (item_mode == MODE_CUBE);
                degen_reg <= 1'b0;
            end
            OP_ACC_CLR:    acc_reg <= '0;
            OP_MUL_CLIP,
            OP_MUL_TEST,
            OP_MUL_SQ:     prod_reg <= mul_p;
            OP_ACC_SHIFT:  acc_reg <= acc_reg + 72'(prod_reg >>> FRAC_BITS);
            OP_ACC_RAW:    acc_reg <= acc_reg + 72'(prod_reg);
            OP_ACC_D:      acc_reg <= acc_reg + 72'(plane_rd);
            OP_CLIP_STORE: clip_reg[cmd.entry] <= sat32(acc_reg);
            OP_RAW_W:      tmp_reg <= clip_rd;
            OP_RAW_E:      raw_reg[cmd.comp] <= sat32(raw_sum);
            OP_SQRT_INIT:
            begin
                s_reg    <= acc_reg[63:0];
                root_reg <= '0;
                sq_reg   <= '0;
            end
            OP_SQRT_STEP:
            begin
                if (trial_sq <= 65'(s_reg))
                begin
                    root_reg <= root_reg | (32'd1 << cmd.bit_idx);
                    sq_reg   <= trial_sq[63:0];
                end
            end
            OP_DIV_INIT:
            begin
                dvd_reg <= {mag, {FRAC_BITS{1'b0}}};
                rem_reg <= '0;
                quo_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= rem_ge ? 32'(rem_sh - {1'b0, root_reg}) : rem_sh[31:0];
                quo_reg <= {quo_reg[NW-2:0], rem_ge};
                dvd_reg <= dvd_reg << 1;
            end
            OP_DIV_STORE:
            begin
                if (root_reg == 32'd0)
                begin
                    degen_reg <= 1'b1;
                end
            end
            OP_TEST_CMP:
            begin
                if (acc_reg <= limit)
                begin
                    vis_reg <= 1'b0;
                end
            end
            OP_RESULT:
            begin
                out_vis_reg   <= vis_reg;
                out_degen_reg <= degen_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.mode     = mode_reg;
    assign status.out_free = !out_valid_reg || result_ready;

    assign result_valid      = out_valid_reg;
    assign result_visible    = out_vis_reg;
    assign result_degenerate = out_degen_reg;

endmodule

`default_nettype wire

>>> rtl/vfc_controller.sv
// ----------------------------------------------------------------------------
// vfc_controller
// Sequencer of the frustum culler: walks the clip product, plane extraction
// with square root and division, and the plane tests over the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vfc_controller #(
    parameter int FRAC_BITS  = vfc_pkg::FRAC_BITS_DEF,
    parameter int SQRT_STEPS = vfc_pkg::SQRT_STEPS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  vfc_pkg::dp_status_t status,
    output vfc_pkg::dp_cmd_t    cmd
);
    import vfc_pkg::*;

    localparam int NW         = 32 + FRAC_BITS;
    localparam int DCW        = $clog2(NW);
    localparam int ROOT_STEPS = (SQRT_STEPS > 32) ? 32 : SQRT_STEPS;
    localparam logic [4:0] ROOT_LAST  = 5'(32 - ROOT_STEPS);
    localparam logic [2:0] PLANE_LAST = 3'(PLANE_COUNT - 1);

    ctl_state_t     state_reg, state_next;
    logic [3:0]     entry_reg, entry_next;
    logic [1:0]     k_reg, k_next;
    logic [2:0]     p_reg, p_next;
    logic [1:0]     comp_reg, comp_next;
    logic [4:0]     bit_reg, bit_next;
    logic [DCW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            entry_reg <= '0;
            k_reg     <= '0;
            p_reg     <= '0;
            comp_reg  <= '0;
            bit_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            k_reg     <= k_next;
            p_reg     <= p_next;
            comp_reg  <= comp_next;
            bit_reg   <= bit_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        entry_next  = entry_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        comp_next   = comp_reg;
        bit_next    = bit_reg;
        cnt_next    = cnt_reg;
        item_ready  = 1'b0;
        cmd.op      = OP_NOP;
        cmd.entry   = entry_reg;
        cmd.k       = k_reg;
        cmd.plane   = p_reg;
        cmd.comp    = comp_reg;
        cmd.bit_idx = bit_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                entry_next = '0;
                p_next     = '0;
                comp_next  = '0;
                unique case (status.mode) inside
                    MODE_EXTRACT:                      state_next = S_CLIP_CLR;
                    MODE_POINT, MODE_SPHERE, MODE_CUBE: state_next = S_TEST_CLR;
                    default:                           state_next = S_FINISH;
                endcase
            end
            S_CLIP_CLR:
            begin
                cmd.op     = OP_ACC_CLR;
                k_next     = '0;
                state_next = S_CLIP_MUL;
            end
            S_CLIP_MUL:
            begin
                cmd.op     = OP_MUL_CLIP;
                state_next = S_CLIP_ACC;
            end
            S_CLIP_ACC:
            begin
                cmd.op     = OP_ACC_SHIFT;
                k_next     = k_reg + 2'd1;
                state_next = (k_reg == 2'd3) ? S_CLIP_STORE : S_CLIP_MUL;
            end
            S_CLIP_STORE:
            begin
                cmd.op     = OP_CLIP_STORE;
                entry_next = entry_reg + 4'd1;
                if (entry_reg == 4'd15)
                begin
                    comp_next  = '0;
                    state_next = S_RAW_W;
                end
                else
                begin
                    state_next = S_CLIP_CLR;
                end
            end
            S_RAW_W:
            begin
                cmd.op     = OP_RAW_W;
                state_next = S_RAW_E;
            end
            S_RAW_E:
            begin
                cmd.op     = OP_RAW_E;
                comp_next  = comp_reg + 2'd1;
                state_next = (comp_reg == 2'd3) ? S_SQ_CLR : S_RAW_W;
            end
            S_SQ_CLR:
            begin
                cmd.op     = OP_ACC_CLR;
                comp_next  = '0;
                state_next = S_SQ_MUL;
            end
            S_SQ_MUL:
            begin
                cmd.op     = OP_MUL_SQ;
                state_next = S_SQ_ACC;
            end
            S_SQ_ACC:
            begin
                cmd.op    = OP_ACC_RAW;
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd2)
                begin
                    comp_next  = '0;
                    state_next = S_SQRT_INIT;
                end
                else
                begin
                    state_next = S_SQ_MUL;
                end
            end
            S_SQRT_INIT:
            begin
                cmd.op     = OP_SQRT_INIT;
                bit_next   = 5'd31;
                state_next = S_SQRT_STEP;
            end
            S_SQRT_STEP:
            begin
                cmd.op   = OP_SQRT_STEP;
                bit_next = bit_reg - 5'd1;
                if (bit_reg == ROOT_LAST)
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_DIV_INIT:
            begin
                cmd.op     = OP_DIV_INIT;
                cnt_next   = '0;
                state_next = S_DIV_STEP;
            end
            S_DIV_STEP:
            begin
                cmd.op   = OP_DIV_STEP;
                cnt_next = cnt_reg + DCW'(1);
                if (cnt_reg == DCW'(NW - 1))
                begin
                    state_next = S_DIV_STORE;
                end
            end
            S_DIV_STORE:
            begin
                cmd.op    = OP_DIV_STORE;
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd3)
                begin
                    p_next     = p_reg + 3'd1;
                    state_next = (p_reg == PLANE_LAST) ? S_FINISH : S_RAW_W;
                end
                else
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_TEST_CLR:
            begin
                cmd.op     = OP_ACC_CLR;
                comp_next  = '0;
                state_next = S_TEST_MUL;
            end
            S_TEST_MUL:
            begin
                cmd.op     = OP_MUL_TEST;
                state_next = S_TEST_ACC;
            end
            S_TEST_ACC:
            begin
                cmd.op    = OP_ACC_SHIFT;
                comp_next = comp_reg + 2'd1;
                state_next = (comp_reg == 2'd2) ? S_TEST_D : S_TEST_MUL;
            end
            S_TEST_D:
            begin
                cmd.op     = OP_ACC_D;
                state_next = S_TEST_CMP;
            end
            S_TEST_CMP:
            begin
                cmd.op     = OP_TEST_CMP;
                p_next     = p_reg + 3'd1;
                state_next = (p_reg == PLANE_LAST) ? S_FINISH : S_TEST_CLR;
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/view_frustum_culler_top.sv
// Load and unused modes go straight to the result; point, sphere and cube tests take each
// plane through the shared multiplier, and an extract runs, for each plane, the bit-serial
// square root (R = min(SQRT_STEPS, 32) steps) and the one-bit-per-cycle divider.
// One item at a time; the next item can be taken as soon as the result is registered.
// Reset (rst_n, asynchronous) clears both matrices and all planes to zero.
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// view_frustum_culler_top
// Frustum plane extraction from modelview and projection matrices, with point,
// sphere and cube visibility tests against the stored planes.
// ----------------------------------------------------------------------------
module view_frustum_culler_top #(
    parameter int FRAC_BITS  = vfc_pkg::FRAC_BITS_DEF,
    parameter int SQRT_STEPS = vfc_pkg::SQRT_STEPS_DEF
) (
    input logic          clk,
    input logic          rst_n,
    vfc_item_if.sink     item,
    vfc_result_if.source result
);
    import vfc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    vfc_controller #(
        .FRAC_BITS  (FRAC_BITS),
        .SQRT_STEPS (SQRT_STEPS)
    ) u_ctl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .status     (status),
        .cmd        (cmd)
    );

    vfc_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .item_mode          (item.mode),
        .item_element_index (item.element_index),
        .item_element_value (item.element_value),
        .item_x_coord       (item.x_coord),
        .item_y_coord       (item.y_coord),
        .item_z_coord       (item.z_coord),
        .item_extent        (item.extent),
        .result_valid       (result.valid),
        .result_ready       (result.ready),
        .result_visible     (result.visible),
        .result_degenerate  (result.degenerate)
    );

endmodule

`default_nettype wire

>>> rtl/vfc_checker.sv
// ----------------------------------------------------------------------------
// vfc_checker
// Port-level checks of the frustum culler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "view_frustum_culler_top_macros.svh"

module vfc_checker (
    input logic clk,
    input logic rst_n,
    input logic item_valid,
    input logic item_ready,
    input logic result_valid,
    input logic result_ready,
    input logic result_visible,
    input logic result_degenerate
);

    // A stalled result item must stay offered with the same contents.
    `VFC_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid)
    `VFC_ASSERT_NEXT(a_result_stable, result_valid && !result_ready, $stable({result_visible, result_degenerate}))
    // Items are worked on one at a time, so the block is busy after an acceptance.
    `VFC_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready)
    // Only an extract reports a degenerate plane, and it never reports visibility.
    `VFC_ASSERT_SAME(a_flags_exclusive, result_valid, !(result_visible && result_degenerate))

endmodule

bind view_frustum_culler_top vfc_checker u_vfc_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .result_visible    (result.visible),
    .result_degenerate (result.degenerate)
);

`default_nettype wire
